// File: design/hdlfd_pkg.sv
package hdlfd_pkg;

	localparam logic [7:0]  FLAG_BYTE  = 8'h7e;
	localparam logic [7:0]  ESC_BYTE   = 8'h7d;
	localparam logic [7:0]  ESC_XOR    = 8'h20;
	localparam logic [15:0] CHECK_INIT = 16'hffff;
	localparam logic [15:0] CHECK_GOOD = 16'hf0b8;
	localparam logic [15:0] CHECK_POLY = 16'h8408;
	localparam logic [15:0] MAX_FRAME_RESET = 16'd8192;

	localparam int MID_DEPTH_DEFAULT = 2;
	localparam int OUT_DEPTH_DEFAULT = 2;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2,
		KIND_OVER = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		MODE_HUNT  = 3'b001,
		MODE_FRAME = 3'b010,
		MODE_ESC   = 3'b100
	} mode_t;

	// A classified line byte as it travels from the front to the back.
	typedef struct packed {
		logic       is_flag;
		logic       is_esc;
		logic [7:0] raw;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} result_t;

	// Reflected CRC-16/X.25 update by one byte.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CHECK_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: design/hdlc_lite_frame_decoder_top.sv
// HDLC-lite deframer with a CRC-16/X.25 check.
// Line bytes enter as beats on the input queue (push, full, in_byte); a beat is taken
// at a clock edge with push high and full low. Results leave through the result
// queue (empty, pop, out_kind, out_byte): while empty is low the oldest result is
// shown, and pop takes it. out_kind is 0 for a payload byte, 1 for a good frame,
// 2 for a bad or short frame and 3 for overflow; out_byte is zero unless it is 0.
// The frame size limit is written through cfg_we and cfg_wdata; the user must write
// it only while the block idles, which the block itself does not enforce.
// Throughput is one line byte per cycle while the result queue has room, set by
// the back stage that updates the sync state, byte count and a byte-wide CRC step
// together. A byte is registered in the middle queue between the classifying front
// and the back, and its result is registered again in the result queue.
// When the receiver stops popping, the result queue fills, the back holds, the
// middle queue fills and full rises; no beat is lost and none is repeated.
// Reset clears both queues and puts the block into hunting for an opening flag,
// with the limit back at 8192 bytes.
module hdlc_lite_frame_decoder_top #(
	parameter int MID_DEPTH = hdlfd_pkg::MID_DEPTH_DEFAULT,
	parameter int OUT_DEPTH = hdlfd_pkg::OUT_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	hdlfd_pkg::item_t   item;
	hdlfd_pkg::result_t res;
	hdlfd_pkg::result_t head;
	logic               item_valid;
	logic               item_take;
	logic               res_push;
	logic               res_full;

	hdlfd_front #(
		.MID_DEPTH(MID_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_byte   (in_byte),
		.full      (full),
		.item_valid(item_valid),
		.item_take (item_take),
		.item      (item)
	);

	hdlfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item_valid(item_valid),
		.item      (item),
		.item_take (item_take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	hdlfd_fifo #(
		.WIDTH($bits(hdlfd_pkg::result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (head),
		.empty (empty)
	);

	assign out_kind = head.kind;
	assign out_byte = head.data;

endmodule

// File: design/hdlfd_fifo.sv
module hdlfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/hdlfd_front.sv
module hdlfd_front #(
	parameter int MID_DEPTH = hdlfd_pkg::MID_DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        in_byte,
	output logic              full,
	output logic              item_valid,
	input  logic              item_take,
	output hdlfd_pkg::item_t  item
);

	hdlfd_pkg::item_t cls;
	logic             mid_empty;

	// Flag and escape are recognised here; what they mean depends on the back's sync state.
	always_comb begin
		cls.is_flag = (in_byte == hdlfd_pkg::FLAG_BYTE);
		cls.is_esc  = (in_byte == hdlfd_pkg::ESC_BYTE);
		cls.raw     = in_byte;
	end

	hdlfd_fifo #(
		.WIDTH($bits(hdlfd_pkg::item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (item_take),
		.rdata (item),
		.empty (mid_empty)
	);

	assign item_valid = !mid_empty;

endmodule

// File: design/hdlfd_back.sv
module hdlfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                item_valid,
	input  hdlfd_pkg::item_t    item,
	output logic                item_take,
	input  logic                res_full,
	output logic                res_push,
	output hdlfd_pkg::result_t  res
);

	hdlfd_pkg::mode_t mode_q, mode_n;
	logic [15:0]      crc_q, crc_n;
	logic [15:0]      count_q, count_n;
	logic [15:0]      max_q;
	logic [7:0]       held_q [2];
	logic             take;
	logic             shift;
	logic             has_res;
	logic [7:0]       dbyte;

	// The back advances only when the result queue can take a beat, whether or not one comes.
	assign item_take = item_valid && !res_full;
	assign res_push  = item_take && has_res;

	assign dbyte = (mode_q == hdlfd_pkg::MODE_ESC) ? (item.raw ^ hdlfd_pkg::ESC_XOR) : item.raw;

	always_comb begin
		mode_n   = mode_q;
		crc_n    = crc_q;
		count_n  = count_q;
		take     = 1'b0;
		shift    = 1'b0;
		has_res  = 1'b0;
		res.kind = hdlfd_pkg::KIND_DATA;
		res.data = 8'h00;
		unique case (mode_q)
			hdlfd_pkg::MODE_FRAME: begin
				if (item.is_esc) begin
					mode_n = hdlfd_pkg::MODE_ESC;
				end else if (item.is_flag) begin
					if (count_q != 16'd0) begin
						has_res = 1'b1;
						if (count_q >= 16'd2 && crc_q == hdlfd_pkg::CHECK_GOOD) begin
							res.kind = hdlfd_pkg::KIND_GOOD;
						end else begin
							res.kind = hdlfd_pkg::KIND_BAD;
						end
					end
					count_n = 16'd0;
					crc_n   = hdlfd_pkg::CHECK_INIT;
				end else begin
					take = 1'b1;
				end
			end
			hdlfd_pkg::MODE_ESC: begin
				take = 1'b1;
			end
			default: begin
				if (item.is_flag) begin
					mode_n  = hdlfd_pkg::MODE_FRAME;
					count_n = 16'd0;
					crc_n   = hdlfd_pkg::CHECK_INIT;
				end
			end
		endcase
		if (take) begin
			if (count_q >= max_q) begin
				// The byte is dropped and the block hunts for the next flag.
				mode_n   = hdlfd_pkg::MODE_HUNT;
				has_res  = 1'b1;
				res.kind = hdlfd_pkg::KIND_OVER;
			end else begin
				crc_n   = hdlfd_pkg::crc_update(crc_q, dbyte);
				shift   = 1'b1;
				count_n = count_q + 16'd1;
				mode_n  = hdlfd_pkg::MODE_FRAME;
				if (count_q >= 16'd2) begin
					has_res  = 1'b1;
					res.kind = hdlfd_pkg::KIND_DATA;
					res.data = held_q[0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take && shift) begin
			held_q[0] <= held_q[1];
			held_q[1] <= dbyte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= hdlfd_pkg::MODE_HUNT;
			crc_q   <= hdlfd_pkg::CHECK_INIT;
			count_q <= 16'd0;
			max_q   <= hdlfd_pkg::MAX_FRAME_RESET;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (item_take) begin
				mode_q  <= mode_n;
				crc_q   <= crc_n;
				count_q <= count_n;
			end
		end
	end

endmodule

// File: design/hdlfd_checker.sv
module hdlfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  out_kind,
	input logic [7:0]  out_byte
);

	// Both queues come out of reset empty.
	a_reset_clear: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queues not empty during reset");

	// Only payload beats carry a byte.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind != hdlfd_pkg::KIND_DATA) |-> (out_byte == 8'h00))
		else $error("status beat carries a non-zero byte");

	// A result that is not taken stays on the ports unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_byte)))
		else $error("waiting result changed or vanished");

	// The input side can only fill up through a beat that was pushed.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

endmodule

bind hdlc_lite_frame_decoder_top hdlfd_checker u_hdlfd_checker (.*);

// File: tb/hdlfd_tb_pkg.sv
package hdlfd_tb_pkg;

	import hdlfd_pkg::*;

	// Tracks the deframer state beat by beat and keeps the results still owed by the block.
	class deframe_tracker;
		logic [15:0] size_limit;
		mode_t       sync;
		logic [15:0] fcs;
		logic [15:0] nbytes;
		logic [7:0]  delay_line [2];
		result_t     due_results [$];
		int unsigned errors;

		function new();
			size_limit = MAX_FRAME_RESET;
			sync = MODE_HUNT;
			fcs = CHECK_INIT;
			nbytes = '0;
			delay_line[0] = '0;
			delay_line[1] = '0;
			errors = 0;
		endfunction

		// Bit-serial form of the reflected X.25 update, one data bit per shift.
		static function logic [15:0] fcs_step(logic [15:0] acc, logic [7:0] b);
			logic [15:0] r;
			r = acc;
			for (int i = 0; i < 8; i++) begin
				if (r[0] ^ b[i]) begin
					r = (r >> 1) ^ CHECK_POLY;
				end else begin
					r = r >> 1;
				end
			end
			return r;
		endfunction

		function void add_result(kind_t k, logic [7:0] d);
			result_t r;
			r.kind = k;
			r.data = d;
			due_results.push_back(r);
		endfunction

		function void take_decoded(logic [7:0] b);
			if (nbytes >= size_limit) begin
				sync = MODE_HUNT;
				add_result(KIND_OVER, 8'h00);
				return;
			end
			fcs = fcs_step(fcs, b);
			if (nbytes >= 16'd2) begin
				add_result(KIND_DATA, delay_line[0]);
			end
			delay_line[0] = delay_line[1];
			delay_line[1] = b;
			nbytes = nbytes + 16'd1;
			sync = MODE_FRAME;
		endfunction

		// Returns 0 when the beat was ignored while hunting for a flag.
		function bit note_byte(logic [7:0] b);
			bit live;
			live = 1'b1;
			case (sync)
				MODE_FRAME: begin
					if (b == ESC_BYTE) begin
						sync = MODE_ESC;
					end else if (b == FLAG_BYTE) begin
						if (nbytes != 16'd0) begin
							if (nbytes >= 16'd2 && fcs == CHECK_GOOD) begin
								add_result(KIND_GOOD, 8'h00);
							end else begin
								add_result(KIND_BAD, 8'h00);
							end
						end
						nbytes = '0;
						fcs = CHECK_INIT;
					end else begin
						take_decoded(b);
					end
				end
				MODE_ESC: begin
					take_decoded(b ^ ESC_XOR);
				end
				default: begin
					sync = MODE_HUNT;
					if (b == FLAG_BYTE) begin
						sync = MODE_FRAME;
						nbytes = '0;
						fcs = CHECK_INIT;
					end else begin
						live = 1'b0;
					end
				end
			endcase
			return live;
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40) begin
				$display("check error: %s", what);
			end
		endtask

		task check_result(logic [1:0] kind, logic [7:0] data);
			result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected result kind %0d byte %02h", kind, data));
				return;
			end
			want = due_results.pop_front();
			if (kind !== want.kind) begin
				report($sformatf("kind %0d, wanted %0d", kind, want.kind));
			end
			if (data !== want.data) begin
				report($sformatf("byte %02h, wanted %02h (kind %0d)", data, want.data, want.kind));
			end
		endtask
	endclass

endpackage

// File: tb/hdlc_lite_frame_decoder_top_tb.sv
module hdlc_lite_frame_decoder_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import hdlfd_pkg::*;
	import hdlfd_tb_pkg::*;

	localparam int SETTLE_CYCLES = 16;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  in_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;

	deframe_tracker sb = new();
	logic [7:0]     line_q [$];
	int             sent_beats;
	int             tx_idle_pct = 0;
	int             rx_stall_pct = 0;
	int             hold_cycles = 0;

	hdlc_lite_frame_decoder_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_byte  (in_byte),
		.empty    (empty),
		.pop      (pop),
		.out_kind (out_kind),
		.out_byte (out_byte),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Result side: a long hold-off, when requested, takes precedence over random stalls.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_result(out_kind, out_byte);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	function automatic logic [7:0] pick_value();
		case ($urandom_range(7))
			0: return FLAG_BYTE;
			1: return ESC_BYTE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void put_escaped(logic [7:0] b, bit extra_esc);
		if (b == FLAG_BYTE || b == ESC_BYTE || extra_esc) begin
			line_q.push_back(ESC_BYTE);
			line_q.push_back(b ^ ESC_XOR);
		end else begin
			line_q.push_back(b);
		end
	endfunction

	// Wraps a payload with its FCS and flags; spoil flips one bit so the check fails.
	function automatic void add_frame(logic [7:0] body [$], bit spoil);
		logic [15:0] acc;
		logic [7:0]  wire_bytes [$];
		acc = CHECK_INIT;
		wire_bytes = body;
		foreach (body[k]) begin
			acc = deframe_tracker::fcs_step(acc, body[k]);
		end
		acc = ~acc;
		wire_bytes.push_back(acc[7:0]);
		wire_bytes.push_back(acc[15:8]);
		if (spoil) begin
			wire_bytes[$urandom_range(wire_bytes.size() - 1)] ^= 8'h01 << $urandom_range(7);
		end
		line_q.push_back(FLAG_BYTE);
		foreach (wire_bytes[k]) begin
			put_escaped(wire_bytes[k], $urandom_range(15) == 0);
		end
		line_q.push_back(FLAG_BYTE);
	endfunction

	// Leaves push high after the last beat; the caller lowers it.
	task automatic send_line();
		logic [7:0] b;
		while (line_q.size() > 0) begin
			b = line_q.pop_front();
			while ($urandom_range(99) < tx_idle_pct) begin
				push <= 1'b0;
				@(posedge clk);
			end
			push <= 1'b1;
			in_byte <= b;
			do begin
				@(posedge clk);
			end while (full);
			void'(sb.note_byte(b));
			sent_beats++;
		end
	endtask

	task automatic settle();
		while (sb.due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.size_limit = v;
	endtask

	initial begin
		logic [7:0]  body [$];
		logic [15:0] lim;
		int          target;
		int          sel;
		int          n;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at the reset limit: empty frame, good frame with escaped content,
		// a one-byte frame, a flag taken as data after an escape, and a bad check.
		line_q = {FLAG_BYTE, FLAG_BYTE};
		body = {8'h00, 8'hff, 8'h7e};
		add_frame(body, 1'b0);
		line_q.push_back(8'h41);
		line_q.push_back(FLAG_BYTE);
		line_q.push_back(ESC_BYTE);
		line_q.push_back(FLAG_BYTE);
		line_q.push_back(FLAG_BYTE);
		line_q.push_back(8'h12);
		line_q.push_back(8'h34);
		line_q.push_back(8'h56);
		line_q.push_back(FLAG_BYTE);
		send_line();
		push <= 1'b0;
		settle();

		// Limits below range: the first byte overflows, then the escaped second one does.
		write_limit(16'd0);
		line_q = {FLAG_BYTE, 8'h00};
		send_line();
		push <= 1'b0;
		settle();
		write_limit(16'd1);
		line_q = {FLAG_BYTE, 8'h01, ESC_BYTE, 8'h5e};
		send_line();
		push <= 1'b0;
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: lim = MAX_FRAME_RESET;
				1: lim = 16'hffff;
				2: lim = 16'd2;
				3: lim = 16'($urandom_range(3, 40));
				4: lim = 16'd0;
				5: lim = 16'd1;
				6: lim = 16'($urandom_range(41, 400));
				default: lim = 16'($urandom_range(3, 24));
			endcase
			case (ph)
				0, 1: target = 300;
				2: target = 200;
				3: target = 250;
				4, 5: target = 40;
				6: target = 250;
				default: target = 270;
			endcase
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
				default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
			endcase
			write_limit(lim);
			sent_beats = 0;
			// Hold the result side off so both internal queues fill and full rises.
			if (ph == 0) begin
				hold_cycles = 150;
			end
			while (sent_beats < target) begin
				sel = $urandom_range(19);
				n = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(20);
				body.delete();
				for (int k = 0; k < n; k++) begin
					body.push_back(pick_value());
				end
				if (sel < 13) begin
					add_frame(body, 1'b0);
				end else if (sel < 15) begin
					add_frame(body, 1'b1);
				end else if (sel == 15) begin
					line_q.push_back(FLAG_BYTE);
					repeat ($urandom_range(1)) put_escaped(pick_value(), 1'b0);
					line_q.push_back(FLAG_BYTE);
				end else if (sel == 16) begin
					line_q.push_back(FLAG_BYTE);
					foreach (body[k]) begin
						put_escaped(body[k], 1'b0);
					end
					line_q.push_back(ESC_BYTE);
					line_q.push_back(FLAG_BYTE);
					line_q.push_back(FLAG_BYTE);
				end else begin
					repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(255)));
				end
				send_line();
			end
			push <= 1'b0;
			settle();
		end

		rx_stall_pct = 0;
		settle();
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
